// ===== rtl/lfrc_pkg.sv =====
// Package for the length-framed response checker.
// Holds field widths, result codes, the result item type and tdata packing.
// No dependencies.
`default_nettype none

package lfrc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned SUM_W     = 16;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned HDR_LEN_POS = 3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_CSUM = 2'd2;

   typedef struct packed {
      logic                result_kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   payload_index;
      logic [STATUS_W-1:0] frame_status;
      logic [BYTE_W-1:0]   payload_length;
   } rsp_item_type;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp_data(input rsp_item_type item);
      pack_rsp_data = {6'd0, item.payload_length, item.frame_status,
                       item.payload_index, item.payload_byte};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/length_framed_response_checker_unit.sv =====
// Length-framed response checker: frame parser, checksum check and a
// two-entry output buffer. Depends on lfrc_pkg.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  req     | in  | rx_byte[7:0]                                        | frame_start
//  rsp     | out | payload_byte, payload_index, frame_status,         | result_kind
//          |     | payload_length, 6 zero bits                         |
//
// A byte is taken each cycle while the skid register is empty; parse state updates
// at the accepting edge, where any result lands in the output register, or in the
// skid register if the output is full and not popped. The sum is 16 bits wide.
// Synchronous reset returns the parser to header byte 0 and empties the buffer.
// A skid register holds one extra result; req_tready drops only while it is full.
`default_nettype none

module length_framed_response_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  wire logic        req_tuser,   // frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [lfrc_pkg::RSP_DATA_W-1:0] rsp_tdata, // byte, index, status, length
   output logic             rsp_tuser    // result_kind
);
   import lfrc_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_CSUM_HI,
      PH_CSUM_LO
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]   length_ff, length_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [BYTE_W-1:0]   csum_hi_ff, csum_hi_in;

   rsp_item_type        out_ff, skid_ff, new_item;
   logic                out_valid_ff, skid_valid_ff;
   logic                new_valid;

   phase_type           cur_phase;
   logic [BYTE_W-1:0]   cur_count;
   logic [BYTE_W-1:0]   count_inc;
   logic [SUM_W-1:0]    received;
   logic [SUM_W-1:0]    expected;
   logic                accept, pop;

   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.result_kind;
   assign rsp_tdata  = pack_rsp_data(out_ff);

   assign cur_phase = req_tuser ? PH_HEADER : phase_ff;
   assign cur_count = req_tuser ? '0 : count_ff;
   assign count_inc = cur_count + 8'd1;
   assign received  = {csum_hi_ff, req_tdata};
   assign expected  = SUM_W'(0) - sum_ff;

   always_comb begin
      phase_in   = cur_phase;
      count_in   = cur_count;
      length_in  = length_ff;
      sum_in     = sum_ff;
      csum_hi_in = csum_hi_ff;
      new_valid  = 1'b0;
      new_item   = '0;
      case (cur_phase)
         PH_HEADER: begin
            if (cur_count == BYTE_W'(HDR_LEN_POS)) begin
               length_in = req_tdata;
               sum_in    = {8'd0, req_tdata};
               count_in  = '0;
               phase_in  = (req_tdata == '0) ? PH_CSUM_HI : PH_PAYLOAD;
            end else begin
               count_in = count_inc;
            end
         end
         PH_PAYLOAD: begin
            new_valid              = 1'b1;
            new_item.result_kind   = KIND_PAYLOAD;
            new_item.payload_byte  = req_tdata;
            new_item.payload_index = cur_count;
            sum_in   = sum_ff + {8'd0, req_tdata};
            count_in = count_inc;
            if (count_inc == length_ff) begin
               phase_in = PH_CSUM_HI;
            end
         end
         PH_CSUM_HI: begin
            csum_hi_in = req_tdata;
            phase_in   = PH_CSUM_LO;
         end
         PH_CSUM_LO: begin
            new_valid               = 1'b1;
            new_item.result_kind    = KIND_STATUS;
            new_item.payload_length = length_ff;
            if (received == '0) begin
               new_item.frame_status = STATUS_ZERO_CSUM;
            end else if (received != expected) begin
               new_item.frame_status = STATUS_MISMATCH;
            end else begin
               new_item.frame_status = STATUS_OK;
            end
            phase_in = PH_HEADER;
            count_in = '0;
         end
         default: begin
            phase_in = PH_HEADER;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         count_ff      <= '0;
         length_ff     <= '0;
         sum_ff        <= '0;
         csum_hi_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            length_ff  <= length_in;
            sum_ff     <= sum_in;
            csum_hi_ff <= csum_hi_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && new_valid) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= new_item;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= new_item;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid && req_tready)
      else $error("output buffer not empty after reset");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |->
         out_ff.frame_status == STATUS_OK && out_ff.payload_length == '0)
      else $error("payload item carries status fields");

   a_payload_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> length_ff != '0 && count_ff < length_ff)
      else $error("payload phase with index beyond length");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> count_ff < BYTE_W'(HDR_LEN_POS + 1))
      else $error("header byte count out of range");

endmodule

`default_nettype wire

// ===== bench/length_framed_response_checker_unit_tb.sv =====
// Testbench for length_framed_response_checker_unit: random and directed response frames,
// with a scoreboard that predicts payload and status items and checks them field by field.
// Depends on lfrc_pkg and the unit under test; nothing else.
module length_framed_response_checker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfrc_pkg::*;

   localparam int unsigned TOTAL_ITEMS    = 1600;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned FULL_FRAME     = 1000;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_PAYLOAD,
      PARSE_CSUM_HI,
      PARSE_CSUM_LO
   } parse_phase_type;

   typedef enum int unsigned {
      CSUM_GOOD,
      CSUM_ZERO,
      CSUM_FLIP,
      CSUM_RANDOM
   } csum_mode_type;

   typedef enum int unsigned {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS
   } payload_fill_type;

   class frame_scoreboard_type;
      parse_phase_type   phase;
      logic [7:0]        count;
      logic [7:0]        frame_len;
      logic [7:0]        csum_high;
      logic [15:0]       payload_sum;
      rsp_item_type      expected_rsps[$];
      int unsigned       fail_count;

      function new();
         phase       = PARSE_HEADER;
         count       = '0;
         frame_len   = '0;
         csum_high   = '0;
         payload_sum = '0;
         fail_count  = 0;
      endfunction

      function int unsigned outstanding();
         return expected_rsps.size();
      endfunction

      function void note_rx_byte(logic [7:0] rx, logic start);
         rsp_item_type item;
         logic [15:0]  rx_csum;
         logic [15:0]  want_csum;
         item = '0;
         if (start) begin
            phase = PARSE_HEADER;
            count = '0;
         end
         case (phase)
            PARSE_HEADER: begin
               if (count == HDR_LEN_POS) begin
                  frame_len   = rx;
                  payload_sum = {8'd0, rx};
                  count       = '0;
                  phase       = (rx == 8'd0) ? PARSE_CSUM_HI : PARSE_PAYLOAD;
               end else begin
                  count = (count + 8'd1) & 8'd3;
               end
            end
            PARSE_PAYLOAD: begin
               item.result_kind   = KIND_PAYLOAD;
               item.payload_byte  = rx;
               item.payload_index = count;
               expected_rsps.push_back(item);
               payload_sum = payload_sum + {8'd0, rx};
               count       = count + 8'd1;
               if (count == frame_len)
                  phase = PARSE_CSUM_HI;
            end
            PARSE_CSUM_HI: begin
               csum_high = rx;
               phase     = PARSE_CSUM_LO;
            end
            default: begin
               rx_csum   = {csum_high, rx};
               want_csum = (payload_sum - 16'd1) ^ 16'hFFFF;
               item.result_kind    = KIND_STATUS;
               item.payload_length = frame_len;
               if (rx_csum == 16'd0)
                  item.frame_status = STATUS_ZERO_CSUM;
               else if (rx_csum != want_csum)
                  item.frame_status = STATUS_MISMATCH;
               else
                  item.frame_status = STATUS_OK;
               expected_rsps.push_back(item);
               phase = PARSE_HEADER;
               count = '0;
            end
         endcase
      endfunction

      function void check_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
         end
      endfunction

      function void check_rsp(logic [RSP_DATA_W-1:0] data, logic kind);
         rsp_item_type want;
         if (expected_rsps.size() == 0) begin
            $error("result with none expected: kind %0d data %h", kind, data);
            fail_count++;
            return;
         end
         want = expected_rsps.pop_front();
         check_field("result_kind", want.result_kind, kind);
         check_field("payload_byte", want.payload_byte, data[7:0]);
         check_field("payload_index", want.payload_index, data[15:8]);
         check_field("frame_status", want.frame_status, data[17:16]);
         check_field("payload_length", want.payload_length, data[25:18]);
         check_field("pad", 0, data[31:26]);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   bit                    calm = 1'b0;
   int unsigned           items_sent = 0;
   int unsigned           idle_cycles = 0;
   frame_scoreboard_type  rsp_board = new();

   length_framed_response_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(logic [7:0] rx, logic start);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      rsp_board.note_rx_byte(rx, start);
      items_sent++;
   endtask

   // cut limits how many bytes of the frame go out, for broken frames
   task automatic send_frame(int unsigned len, csum_mode_type mode, bit with_start,
                             int unsigned cut, payload_fill_type fill);
      logic [7:0]  frame_bytes[$];
      logic [7:0]  pb;
      logic [15:0] sum;
      logic [15:0] csum;
      for (int i = 0; i < 3; i++)
         frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'(len));
      sum = 16'(len);
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ONES:  pb = 8'hFF;
            FILL_ZEROS: pb = 8'h00;
            default:    pb = 8'($urandom_range(0, 255));
         endcase
         frame_bytes.push_back(pb);
         sum = sum + {8'd0, pb};
      end
      case (mode)
         CSUM_GOOD: csum = -sum;
         CSUM_ZERO: csum = 16'd0;
         CSUM_FLIP: csum = (-sum) ^ (16'd1 << $urandom_range(0, 15));
         default:   csum = 16'($urandom);
      endcase
      frame_bytes.push_back(csum[15:8]);
      frame_bytes.push_back(csum[7:0]);
      for (int i = 0; i < frame_bytes.size() && i < cut; i++)
         send_byte(frame_bytes[i], with_start && (i == 0));
   endtask

   initial begin
      int unsigned stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            rsp_board.check_rsp(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("length_framed_response_checker_unit regression: fail");
               $finish;
            end
         end
      end
   end

   initial begin
      int unsigned      r;
      int unsigned      len;
      int unsigned      cut;
      bit               start;
      csum_mode_type    mode;
      payload_fill_type fill;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length: sum is zero, so the good checksum is zero and rejected
      send_frame(0, CSUM_GOOD, 1'b1, FULL_FRAME, FILL_RANDOM);
      // follows a status without frame start
      send_frame(0, CSUM_FLIP, 1'b0, FULL_FRAME, FILL_RANDOM);
      send_frame(1, CSUM_GOOD, 1'b1, FULL_FRAME, FILL_ONES);
      // partial header dropped by the next frame start
      send_frame(3, CSUM_GOOD, 1'b1, 2, FILL_RANDOM);
      send_frame(2, CSUM_ZERO, 1'b1, FULL_FRAME, FILL_ZEROS);

      send_frame(255, CSUM_GOOD, 1'b1, FULL_FRAME, FILL_ONES);

      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            calm = !calm;
         r = $urandom_range(0, 99);
         if (r < 8) begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else begin
            len = $urandom_range(0, 99);
            if (len < 50)
               len = $urandom_range(0, 8);
            else if (len < 95)
               len = $urandom_range(9, 40);
            else if (len < 98)
               len = $urandom_range(0, 255);
            else
               len = 255;
            mode = CSUM_GOOD;
            case ($urandom_range(0, 19))
               0, 1:     mode = CSUM_ZERO;
               2, 3, 4:  mode = CSUM_RANDOM;
               5:        mode = CSUM_FLIP;
               default:  mode = CSUM_GOOD;
            endcase
            case ($urandom_range(0, 19))
               0, 1:    fill = FILL_ONES;
               2:       fill = FILL_ZEROS;
               default: fill = FILL_RANDOM;
            endcase
            if (r < 14) begin
               cut   = $urandom_range(1, len + 5);
               start = 1'b1;
            end else begin
               cut   = FULL_FRAME;
               start = ($urandom_range(0, 99) < 85);
            end
            send_frame(len, mode, start, cut, fill);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_board.fail_count == 0)
         $display("length_framed_response_checker_unit regression: pass");
      else
         $display("length_framed_response_checker_unit regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lfrc_pkg.sv
rtl/length_framed_response_checker_unit.sv
bench/length_framed_response_checker_unit_tb.sv
